FILE: hw/rtl/tsw_pkg.sv
// Shared types and constants for the temperature softmax weights core.
// Holds the divider and exponent unit transaction structs and the root table.
// No dependencies.
`timescale 1ns / 1ps

package tsw_pkg;

   // Minimum temperature in Q16.16, about 1e-4.
   localparam logic [30:0] TEMP_MIN = 31'd7;
   // log2(e) in Q16.16.
   localparam logic [16:0] LOG2E_Q16 = 17'd94548;
   localparam int FRAC_BITS = 16;
   // Weight of 1.0 in Q1.16.
   localparam int ONE_Q16 = 65536;
   // Divider operand widths and the exponent result width.
   localparam int NUM_W = 49;
   localparam int DEN_W = 31;
   localparam int EXP_W = 17;

   typedef logic [FRAC_BITS:0][31:0] root_table_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] numer;
      logic [DEN_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quo;
   } div_rsp_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] x;
   } exp_req_type;

   typedef struct packed {
      logic             done;
      logic [EXP_W-1:0] e;
   } exp_rsp_type;

   // Integer square root of a 64-bit value, evaluated at elaboration.
   function automatic logic [63:0] isqrt64(input logic [63:0] value);
      logic [63:0] n;
      logic [63:0] res;
      logic [63:0] bitv;
      n    = value;
      res  = 64'd0;
      bitv = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Entry i is 2^-(2^-i) in Q0.32, each the square root of the one before.
   function automatic root_table_type build_roots();
      root_table_type tbl;
      logic [63:0]    root;
      tbl[0] = 32'h8000_0000;
      for (int i = 1; i <= FRAC_BITS; i++) begin
         root   = isqrt64({tbl[i-1], 32'd0});
         tbl[i] = root[31:0];
      end
      return tbl;
   endfunction

endpackage

FILE: hw/rtl/tsw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tsw_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/tsw_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on tsw_pkg for the operand widths and transaction structs.
`timescale 1ns / 1ps

module tsw_div (
   input  logic                clock,
   input  logic                reset,
   input  tsw_pkg::div_req_type req,
   output tsw_pkg::div_rsp_type rsp
);
   import tsw_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] qn_ff, qn_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic             qbit;

   // Shift in the next numerator bit and try to subtract the divisor.
   always_comb begin
      trial  = {rem_ff, qn_ff[NUM_W-1]};
      qbit   = (trial >= {1'b0, den_ff});
      qn_in  = {qn_ff[NUM_W-2:0], qbit};
      rem_in = qbit ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
   end

   // Iteration control.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (busy_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (!busy_ff && req.start) begin
         qn_ff  <= req.numer;
         rem_ff <= '0;
         den_ff <= req.denom;
      end else if (busy_ff) begin
         qn_ff  <= qn_in;
         rem_ff <= rem_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = qn_ff;

endmodule

FILE: hw/rtl/tsw_exp.sv
// Exponent unit: turns a scaled score gap x into 2^-(x*log2 e) in Q1.16.
// Depends on tsw_pkg for the root table, constants and transaction structs.
`timescale 1ns / 1ps

module tsw_exp (
   input  logic                clock,
   input  logic                reset,
   input  tsw_pkg::exp_req_type req,
   output tsw_pkg::exp_rsp_type rsp
);
   import tsw_pkg::*;

   typedef enum logic [3:0] {
      E_IDLE = 4'b0001,
      E_MUL  = 4'b0010,
      E_ROOT = 4'b0100,
      E_FIN  = 4'b1000
   } exp_state_type;

   localparam root_table_type ROOTS = build_roots();

   exp_state_type    state_ff, state_in;
   logic [20:0]      x_ff;
   logic             big_ff;
   logic [21:0]      y_ff;
   logic             zero_ff;
   logic [32:0]      v_ff;
   logic [4:0]       step_ff, step_in;
   logic             done_ff;
   logic [EXP_W-1:0] e_ff;

   logic [37:0]      prod_y;
   logic [21:0]      y_full;
   logic [64:0]      prod_v;
   logic [64:0]      v_round;
   logic [4:0]       bit_sel;
   logic [4:0]       n_exp;
   logic [33:0]      rnd;
   logic [33:0]      e_wide;

   // Scale by log2(e) with rounding, then one root multiply per cycle.
   always_comb begin
      prod_y  = 38'(x_ff) * 38'(LOG2E_Q16);
      y_full  = 22'((prod_y + 38'(32768)) >> 16);
      prod_v  = 65'(v_ff) * 65'(ROOTS[step_ff]);
      v_round = (prod_v + (65'(1) << 31)) >> 32;
      bit_sel = 5'd16 - step_ff;
      n_exp   = y_ff[20:16];
      rnd     = 34'(1) << (n_exp + 5'd15);
      e_wide  = (34'(v_ff) + rnd) >> (6'(n_exp) + 6'd16);
   end

   // Sequencer. The step counter stays within the root table.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         E_IDLE: begin
            if (req.start) begin
               state_in = E_MUL;
            end
         end
         E_MUL: begin
            state_in = E_ROOT;
            step_in  = 5'd1;
         end
         E_ROOT: begin
            if (step_ff == 5'(FRAC_BITS)) begin
               state_in = E_FIN;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         E_FIN: begin
            state_in = E_IDLE;
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         step_ff  <= 5'd1;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         done_ff  <= (state_ff == E_FIN);
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (state_ff == E_IDLE && req.start) begin
         x_ff   <= req.x[20:0];
         big_ff <= |req.x[NUM_W-1:21];
      end
      if (state_ff == E_MUL) begin
         y_ff    <= y_full;
         zero_ff <= big_ff || (y_full > 22'(FRAC_BITS << FRAC_BITS));
         v_ff    <= 33'(1) << 32;
      end
      if (state_ff == E_ROOT && y_ff[bit_sel[3:0]]) begin
         v_ff <= v_round[32:0];
      end
      if (state_ff == E_FIN) begin
         e_ff <= zero_ff ? '0 : e_wide[EXP_W-1:0];
      end
   end

   assign rsp.done = done_ff;
   assign rsp.e    = e_ff;

endmodule

FILE: hw/rtl/temperature_softmax_weights_core.sv
// Top level of the temperature softmax weights core.
// Depends on tsw_pkg, tsw_ram, tsw_div and tsw_exp.
`timescale 1ns / 1ps

// Hits are loaded one per cycle while busy is low; a hit without the last flag
// produces nothing. A transaction with batch_last raises busy and starts a pass
// over the stored batch: for each hit the 49-step divider forms the scaled
// gap to the maximum and the exponent unit runs 16 root multiplies; then each
// weight takes another 49-step division in the shared divider. Weights leave one
// at a time on rsp_valid strobes of one cycle, in arrival order; the receiver
// cannot stall them.
// Hits past MAX_HITS are dropped. Scores and chunk ids sit in one RAM and the
// exponentials in a second; each entry is read only after its write phase.
module temperature_softmax_weights_core #(
   parameter int MAX_HITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_hit_score,
   input  logic [31:0] req_hit_chunk,
   input  logic        req_batch_last,
   input  logic        csr_wr_en,
   input  logic [30:0] csr_wr_data,
   output logic        rsp_valid,
   output logic [5:0]  rsp_hit_position,
   output logic [31:0] rsp_out_chunk,
   output logic [16:0] rsp_hit_weight,
   output logic        rsp_weight_last
);
   import tsw_pkg::*;

   localparam int IW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
   localparam int CW = $clog2(MAX_HITS + 1);
   localparam int SW = $clog2(MAX_HITS * ONE_Q16 + 1);

   typedef enum logic [7:0] {
      S_LOAD   = 8'b0000_0001,
      S_X_RD   = 8'b0000_0010,
      S_X_DIV  = 8'b0000_0100,
      S_X_DIVW = 8'b0000_1000,
      S_X_EXPW = 8'b0001_0000,
      S_W_RD   = 8'b0010_0000,
      S_W_DIV  = 8'b0100_0000,
      S_W_DIVW = 8'b1000_0000
   } core_state_type;

   core_state_type     state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic signed [31:0] max_ff, max_in;
   logic [SW-1:0]      sum_ff, sum_in;
   logic [30:0]        temp_ff;
   logic               rsp_valid_ff;
   logic [5:0]         rsp_pos_ff;
   logic [31:0]        rsp_chunk_ff;
   logic [16:0]        rsp_weight_ff;
   logic               rsp_last_ff;

   logic               accept;
   logic               store_hit;
   logic               idx_is_last;
   logic [30:0]        t_eff;
   logic [32:0]        diff;
   logic [63:0]        hit_rd;
   logic [EXP_W-1:0]   exp_rd;
   logic               exp_wr;
   div_req_type        div_req;
   div_rsp_type        div_rsp;
   exp_req_type        exp_req;
   exp_rsp_type        exp_rsp;

   assign accept      = start && (state_ff == S_LOAD);
   assign store_hit   = accept && (count_ff < CW'(MAX_HITS));
   assign idx_is_last = (CW'(idx_ff) + CW'(1)) == count_ff;
   assign t_eff       = (temp_ff < TEMP_MIN) ? TEMP_MIN : temp_ff;
   assign diff        = {max_ff[31], max_ff} - {hit_rd[63], hit_rd[63:32]};
   assign exp_wr      = (state_ff == S_X_EXPW) && exp_rsp.done;

   // Score and chunk store, written while loading.
   tsw_ram #(.WIDTH(64), .DEPTH(MAX_HITS)) u_hit_ram (
      .clock   (clock),
      .wr_en   (store_hit),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data ({req_hit_score, req_hit_chunk}),
      .rd_addr (idx_ff),
      .rd_data (hit_rd)
   );

   // Exponential store, written during the exponent pass.
   tsw_ram #(.WIDTH(EXP_W), .DEPTH(MAX_HITS)) u_exp_ram (
      .clock   (clock),
      .wr_en   (exp_wr),
      .wr_addr (idx_ff),
      .wr_data (exp_rsp.e),
      .rd_addr (idx_ff),
      .rd_data (exp_rd)
   );

   // Divider operands: scaled gap in the exponent pass, weight otherwise.
   always_comb begin
      div_req.start = (state_ff == S_X_DIV) || (state_ff == S_W_DIV);
      if (state_ff == S_X_DIV) begin
         div_req.numer = NUM_W'({diff[31:0], 16'd0}) + NUM_W'(t_eff[30:1]);
         div_req.denom = t_eff;
      end else begin
         div_req.numer = NUM_W'({exp_rd, 16'd0}) + NUM_W'(sum_ff >> 1);
         div_req.denom = DEN_W'(sum_ff);
      end
      exp_req.start = (state_ff == S_X_DIVW) && div_rsp.done;
      exp_req.x     = div_rsp.quo;
   end

   tsw_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   tsw_exp u_exp (
      .clock (clock),
      .reset (reset),
      .req   (exp_req),
      .rsp   (exp_rsp)
   );

   // Batch sequencer.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      max_in   = max_ff;
      sum_in   = sum_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (store_hit) begin
               count_in = count_ff + CW'(1);
               if ($signed(req_hit_score) > max_ff) begin
                  max_in = $signed(req_hit_score);
               end
            end
            if (accept && req_batch_last) begin
               state_in = S_X_RD;
               idx_in   = '0;
               sum_in   = '0;
            end
         end
         S_X_RD: begin
            state_in = S_X_DIV;
         end
         S_X_DIV: begin
            state_in = S_X_DIVW;
         end
         S_X_DIVW: begin
            if (div_rsp.done) begin
               state_in = S_X_EXPW;
            end
         end
         S_X_EXPW: begin
            if (exp_rsp.done) begin
               sum_in = sum_ff + SW'(exp_rsp.e);
               if (idx_is_last) begin
                  idx_in   = '0;
                  state_in = S_W_RD;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = S_X_RD;
               end
            end
         end
         S_W_RD: begin
            state_in = S_W_DIV;
         end
         S_W_DIV: begin
            state_in = S_W_DIVW;
         end
         S_W_DIVW: begin
            if (div_rsp.done) begin
               if (idx_is_last) begin
                  idx_in   = '0;
                  count_in = '0;
                  max_in   = 32'sh8000_0000;
                  sum_in   = '0;
                  state_in = S_LOAD;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = S_W_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         idx_ff       <= '0;
         max_ff       <= 32'sh8000_0000;
         sum_ff       <= '0;
         temp_ff      <= 31'(ONE_Q16);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         max_ff       <= max_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= (state_ff == S_W_DIVW) && div_rsp.done;
         if (csr_wr_en) begin
            temp_ff <= csr_wr_data;
         end
      end
   end

   // Result registers, loaded as each weight division completes.
   always_ff @(posedge clock) begin
      if ((state_ff == S_W_DIVW) && div_rsp.done) begin
         rsp_pos_ff    <= 6'(idx_ff);
         rsp_chunk_ff  <= hit_rd[31:0];
         rsp_weight_ff <= div_rsp.quo[16:0];
         rsp_last_ff   <= idx_is_last;
      end
   end

   assign busy             = (state_ff != S_LOAD);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit_position = rsp_pos_ff;
   assign rsp_out_chunk    = rsp_chunk_ff;
   assign rsp_hit_weight   = rsp_weight_ff;
   assign rsp_weight_last  = rsp_last_ff;

   // The batch never holds more hits than the store.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_HITS))
      else $error("hit count exceeds store depth");

   // The maximum hit contributes exactly one, so the sum is at least one.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_W_RD) |-> (sum_ff >= SW'(ONE_Q16)))
      else $error("exponential sum below one at weight pass");

   // A result follows only a completed weight division and never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff == S_W_DIVW) && (rsp_hit_weight <= 17'(ONE_Q16))))
      else $error("unexpected or out of range result");

endmodule
